// File: hdl/rvex_pkg.sv
// Shared types and constants of the RV64IM execute block.
// Holds the channel structs, the decoded-item format and the instruction codes.
// No dependencies; every other file imports this package.
`default_nettype none
package rvex_pkg;

	typedef struct packed {
		logic        operation;
		logic [31:0] instruction;
		logic [63:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [1:0]  mem_kind;
		logic [63:0] mem_address;
		logic [1:0]  mem_size_log2;
		logic [63:0] mem_write_data;
		logic        writeback_valid;
		logic [4:0]  writeback_index;
		logic [63:0] writeback_value;
		logic [2:0]  status;
		logic [63:0] halt_code;
	} out_item_t;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [1:0] LG_BYTE = 2'd0;
	localparam logic [1:0] LG_HALF = 2'd1;
	localparam logic [1:0] LG_WORD = 2'd2;
	localparam logic [1:0] LG_DBL  = 2'd3;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_HALT     = 3'd1;
	localparam logic [2:0] STAT_ILLEGAL  = 3'd2;
	localparam logic [2:0] STAT_BAD_CSR  = 3'd3;
	localparam logic [2:0] STAT_LOAD_PND = 3'd4;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP32   = 7'h3B;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [31:0] INST_MRET   = 32'h3020_0073;
	localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
	localparam logic [31:0] INST_EBREAK = 32'h0010_0073;

	localparam logic [11:0] CSR_MEPC    = 12'h341;
	localparam logic [11:0] CSR_MCAUSE  = 12'h342;
	localparam logic [11:0] CSR_MSTATUS = 12'h300;
	localparam logic [11:0] CSR_MTVEC   = 12'h305;

	localparam logic [63:0] CAUSE_ECALL_M = 64'hB;
	localparam logic [63:0] RESET_PC      = 64'h8000_0000;
	localparam logic [4:0]  REG_A0        = 5'd10;

	typedef enum logic [3:0] {
		K_ALU, K_JAL, K_JALR, K_BRANCH, K_LOAD, K_STORE, K_CSR, K_CSR_BAD,
		K_MRET, K_ECALL, K_EBREAK, K_ILLEGAL, K_MDU, K_LDATA
	} kind_t;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SRL, ALU_SRA,
		ALU_OR, ALU_AND
	} alu_op_t;

	typedef enum logic [1:0] {A_REG, A_PC, A_ZERO} a_src_t;

	typedef enum logic [2:0] {BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU} br_t;

	typedef enum logic [1:0] {
		CSR_SEL_MEPC, CSR_SEL_MCAUSE, CSR_SEL_MSTATUS, CSR_SEL_MTVEC
	} csr_sel_t;

	typedef enum logic [2:0] {MD_MUL, MD_DIV, MD_DIVU, MD_REM, MD_REMU} md_op_t;

	typedef struct packed {
		kind_t       kind;
		alu_op_t     alu;
		a_src_t      a_src;
		logic        b_imm;
		logic        word;
		br_t         br;
		csr_sel_t    csr;
		logic        csr_set;
		md_op_t      md;
		logic [1:0]  mem_lg;
		logic        ld_uns;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [63:0] imm;
		logic [63:0] load_data;
	} uop_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
		logic   word;
	} md_ctl_t;

	function automatic logic [63:0] sx32(input logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

endpackage
`default_nettype wire

// File: hdl/rvex_front.sv
// Front end: accepts input items and classifies them into decoded micro-ops.
// Depends on rvex_pkg; feeds rvex_queue.
`default_nettype none
module rvex_front (
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  rvex_pkg::in_item_t    in_item,
	output logic                  q_push,
	output rvex_pkg::uop_t        q_data,
	input  wire logic             q_ready
);
	import rvex_pkg::*;

	localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
	localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
	localparam logic [2:0] F3_MUL = 3'd0, F3_DIV = 3'd4, F3_DIVU = 3'd5;
	localparam logic [2:0] F3_REM = 3'd6, F3_REMU = 3'd7;
	localparam logic [2:0] F3_CSRRW = 3'd1, F3_CSRRS = 3'd2, F3_LOAD_BAD = 3'd7;
	localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20, F7_MULDIV = 7'h01;
	localparam logic [5:0] SH_LOGIC = 6'h00, SH_ARITH = 6'h10;

	logic [31:0] inst;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;

	assign inst  = in_item.instruction;
	assign f3    = inst[14:12];
	assign f7    = inst[31:25];
	assign imm_i = {{52{inst[31]}}, inst[31:20]};
	assign imm_s = {{52{inst[31]}}, inst[31:25], inst[11:7]};
	assign imm_b = {{51{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
	assign imm_j = {{43{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
	assign imm_u = {{32{inst[31]}}, inst[31:12], 12'b0};

	assign in_ready = q_ready;
	assign q_push   = in_valid;

	always_comb begin
		q_data           = '0;
		q_data.kind      = K_ILLEGAL;
		q_data.alu       = ALU_ADD;
		q_data.a_src     = A_REG;
		q_data.rd        = inst[11:7];
		q_data.rs1       = inst[19:15];
		q_data.rs2       = inst[24:20];
		q_data.load_data = in_item.load_data;
		if (in_item.operation) begin
			q_data.kind = K_LDATA;
		end else begin
			case (inst[6:0])
				OPC_LUI, OPC_AUIPC: begin
					q_data.kind  = K_ALU;
					q_data.a_src = (inst[6:0] == OPC_LUI) ? A_ZERO : A_PC;
					q_data.b_imm = 1'b1;
					q_data.imm   = imm_u;
				end
				OPC_JAL: begin
					q_data.kind = K_JAL;
					q_data.imm  = imm_j;
				end
				OPC_JALR: begin
					q_data.imm = imm_i;
					if (f3 == F3_ADD) q_data.kind = K_JALR;
				end
				OPC_BRANCH: begin
					q_data.imm  = imm_b;
					q_data.kind = K_BRANCH;
					case (f3)
						F3_BEQ:  q_data.br = BR_EQ;
						F3_BNE:  q_data.br = BR_NE;
						F3_BLT:  q_data.br = BR_LT;
						F3_BGE:  q_data.br = BR_GE;
						F3_BLTU: q_data.br = BR_LTU;
						F3_BGEU: q_data.br = BR_GEU;
						default: q_data.kind = K_ILLEGAL;
					endcase
				end
				OPC_LOAD: begin
					q_data.imm    = imm_i;
					q_data.mem_lg = f3[1:0];
					q_data.ld_uns = f3[2];
					if (f3 != F3_LOAD_BAD) q_data.kind = K_LOAD;
				end
				OPC_STORE: begin
					q_data.imm    = imm_s;
					q_data.mem_lg = f3[1:0];
					if (!f3[2]) q_data.kind = K_STORE;
				end
				OPC_OPIMM: begin
					q_data.kind  = K_ALU;
					q_data.b_imm = 1'b1;
					q_data.imm   = imm_i;
					case (f3)
						F3_ADD:  q_data.alu = ALU_ADD;
						F3_SLT:  q_data.alu = ALU_SLT;
						F3_SLTU: q_data.alu = ALU_SLTU;
						F3_XOR:  q_data.alu = ALU_XOR;
						F3_OR:   q_data.alu = ALU_OR;
						F3_AND:  q_data.alu = ALU_AND;
						F3_SLL: begin
							q_data.alu = ALU_SLL;
							if (inst[31:26] != SH_LOGIC) q_data.kind = K_ILLEGAL;
						end
						default: begin
							if (inst[31:26] == SH_LOGIC) q_data.alu = ALU_SRL;
							else if (inst[31:26] == SH_ARITH) q_data.alu = ALU_SRA;
							else q_data.kind = K_ILLEGAL;
						end
					endcase
				end
				OPC_OPIMM32: begin
					q_data.kind  = K_ALU;
					q_data.word  = 1'b1;
					q_data.b_imm = 1'b1;
					q_data.imm   = imm_i;
					if (f3 == F3_ADD) q_data.alu = ALU_ADD;
					else if (f3 == F3_SLL && f7 == F7_BASE) q_data.alu = ALU_SLL;
					else if (f3 == F3_SRL && f7 == F7_BASE) q_data.alu = ALU_SRL;
					else if (f3 == F3_SRL && f7 == F7_ALT) q_data.alu = ALU_SRA;
					else q_data.kind = K_ILLEGAL;
				end
				OPC_OP, OPC_OP32: begin
					q_data.word = (inst[6:0] == OPC_OP32);
					q_data.kind = K_ALU;
					if (f7 == F7_MULDIV) begin
						q_data.kind = K_MDU;
						case (f3)
							F3_MUL:  q_data.md = MD_MUL;
							F3_DIV:  q_data.md = MD_DIV;
							F3_DIVU: q_data.md = MD_DIVU;
							F3_REM:  q_data.md = MD_REM;
							F3_REMU: q_data.md = MD_REMU;
							default: q_data.kind = K_ILLEGAL;
						endcase
					end else if (f7 == F7_ALT) begin
						if (f3 == F3_ADD) q_data.alu = ALU_SUB;
						else if (f3 == F3_SRL && q_data.word) q_data.alu = ALU_SRA;
						else q_data.kind = K_ILLEGAL;
					end else if (f7 == F7_BASE) begin
						case (f3)
							F3_ADD:  q_data.alu = ALU_ADD;
							F3_SLL:  q_data.alu = ALU_SLL;
							F3_SLT:  q_data.alu = ALU_SLT;
							F3_SLTU: q_data.alu = ALU_SLTU;
							F3_XOR:  q_data.alu = ALU_XOR;
							F3_SRL:  q_data.alu = ALU_SRL;
							F3_OR:   q_data.alu = ALU_OR;
							default: q_data.alu = ALU_AND;
						endcase
						// The word forms only have add, shift left and shift right.
						if (q_data.word && f3 != F3_ADD && f3 != F3_SLL && f3 != F3_SRL)
							q_data.kind = K_ILLEGAL;
					end else begin
						q_data.kind = K_ILLEGAL;
					end
				end
				OPC_SYSTEM: begin
					if (inst == INST_MRET) begin
						q_data.kind = K_MRET;
					end else if (f3 == F3_CSRRW || f3 == F3_CSRRS) begin
						q_data.kind    = K_CSR;
						q_data.csr_set = (f3 == F3_CSRRS);
						case (inst[31:20])
							CSR_MEPC:    q_data.csr = CSR_SEL_MEPC;
							CSR_MCAUSE:  q_data.csr = CSR_SEL_MCAUSE;
							CSR_MSTATUS: q_data.csr = CSR_SEL_MSTATUS;
							CSR_MTVEC:   q_data.csr = CSR_SEL_MTVEC;
							default:     q_data.kind = K_CSR_BAD;
						endcase
					end else if (inst == INST_ECALL) begin
						q_data.kind = K_ECALL;
					end else if (inst == INST_EBREAK) begin
						// The halt code is a0, read through the first port.
						q_data.kind = K_EBREAK;
						q_data.rs1  = REG_A0;
					end
				end
				default: q_data.kind = K_ILLEGAL;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/rvex_queue.sv
// Two-entry queue of decoded micro-ops between the front and back ends.
// Depends on rvex_pkg.
`default_nettype none
module rvex_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rvex_pkg::uop_t     push_data,
	output logic               push_ready,
	output logic               pop_valid,
	input  wire logic          pop,
	output rvex_pkg::uop_t     pop_data
);
	import rvex_pkg::*;

	uop_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// File: hdl/rvex_mdu.sv
// Iterative multiply/divide unit: one bit per cycle, 64 steps plus a finish step.
// Depends on rvex_pkg.
`default_nettype none
module rvex_mdu (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  rvex_pkg::md_ctl_t  ctl,
	input  wire logic [63:0]   a,
	input  wire logic [63:0]   b,
	output logic               done,
	output logic [63:0]        result
);
	import rvex_pkg::*;

	logic        busy_q, done_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q, y_q, aorig_q, res_q;
	logic [64:0] acc_q;
	md_op_t      op_q;
	logic        word_q, neg_q, bzero_q;

	logic        st_signed, st_rem, st_mul;
	logic [63:0] ea, eb, ma, mb;
	logic [64:0] trial;
	logic        q_signed, q_rem;
	logic [63:0] raw, fin;

	assign st_signed = (ctl.op == MD_DIV) || (ctl.op == MD_REM);
	assign st_rem    = (ctl.op == MD_REM) || (ctl.op == MD_REMU);
	assign st_mul    = (ctl.op == MD_MUL);
	assign ea = ctl.word ? (st_signed ? sx32(a) : {32'b0, a[31:0]}) : a;
	assign eb = ctl.word ? (st_signed ? sx32(b) : {32'b0, b[31:0]}) : b;
	assign ma = (st_signed && ea[63]) ? (64'd0 - ea) : ea;
	assign mb = (st_signed && eb[63]) ? (64'd0 - eb) : eb;

	assign trial = {acc_q[63:0], x_q[63]};

	assign q_signed = (op_q == MD_DIV) || (op_q == MD_REM);
	assign q_rem    = (op_q == MD_REM) || (op_q == MD_REMU);

	always_comb begin
		if (op_q == MD_MUL) raw = acc_q[63:0];
		else if (q_rem) raw = acc_q[63:0];
		else raw = x_q;
		if (q_signed && bzero_q) fin = q_rem ? aorig_q : '1;
		else if (q_signed && neg_q) fin = 64'd0 - raw;
		else fin = raw;
		if (word_q) fin = sx32(fin);
	end

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q[6]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q     <= st_mul ? a : ma;
			y_q     <= st_mul ? b : mb;
			acc_q   <= '0;
			op_q    <= ctl.op;
			word_q  <= ctl.word;
			neg_q   <= st_rem ? ea[63] : (ea[63] ^ eb[63]);
			bzero_q <= (eb == 64'd0);
			aorig_q <= ea;
		end else if (busy_q && !cnt_q[6]) begin
			if (op_q == MD_MUL) begin
				if (y_q[0]) acc_q <= {1'b0, acc_q[63:0] + x_q};
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[63:1]};
			end else if (trial >= {1'b0, y_q}) begin
				acc_q <= trial - {1'b0, y_q};
				x_q   <= {x_q[62:0], 1'b1};
			end else begin
				acc_q <= trial;
				x_q   <= {x_q[62:0], 1'b0};
			end
		end else if (busy_q && cnt_q[6]) begin
			res_q <= fin;
		end
	end

endmodule
`default_nettype wire

// File: hdl/rvex_back.sv
// Back end: register file, CSRs, pc, ALU and commit into the output register.
// Depends on rvex_pkg and rvex_mdu.
`default_nettype none
module rvex_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  rvex_pkg::uop_t        q_data,
	input  wire logic             cfg_write,
	input  wire logic [63:0]      cfg_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rvex_pkg::out_item_t   out_item
);
	import rvex_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_MDU  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [63:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	uop_t        d_s1;
	logic [63:0] rs1_s1, rs2_s1, md_val_q;
	logic [63:0] pc_q, mepc_q, mstatus_q, mcause_q, mtvec_q;
	logic        pend_q, pend_uns_q;
	logic [4:0]  pend_rd_q;
	logic [1:0]  pend_lg_q;
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic        out_free, mdu_go, commit;
	md_ctl_t     md_ctl;
	logic        md_done;
	logic [63:0] md_result;
	logic [63:0] alu_a, alu_b, alu_r, addr, pc4, pc_imm, csr_val, ld_val, st_data;
	logic [5:0]  sh;
	logic        taken;
	out_item_t   res;
	logic        wb_req, set_pend, clr_pend, csr_we, ecall;
	logic [4:0]  wb_idx;
	logic [63:0] wb_val;

	assign out_free = !out_valid_q || out_ready;
	assign mdu_go   = (d_s1.kind == K_MDU) && !pend_q;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign commit   = out_free && (((state_q == ST_EXEC) && !mdu_go) || (state_q == ST_FIN));

	assign md_ctl.start = (state_q == ST_EXEC) && mdu_go;
	assign md_ctl.op    = d_s1.md;
	assign md_ctl.word  = d_s1.word;

	rvex_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a      (rs1_s1),
		.b      (rs2_s1),
		.done   (md_done),
		.result (md_result)
	);

	always_comb begin
		case (d_s1.a_src)
			A_PC:    alu_a = pc_q;
			A_ZERO:  alu_a = '0;
			default: alu_a = rs1_s1;
		endcase
		alu_b = d_s1.b_imm ? d_s1.imm : rs2_s1;
		sh    = d_s1.word ? {1'b0, alu_b[4:0]} : alu_b[5:0];
		case (d_s1.alu)
			ALU_SUB:  alu_r = alu_a - alu_b;
			ALU_SLL:  alu_r = alu_a << sh;
			ALU_SLT:  alu_r = {63'b0, $signed(alu_a) < $signed(alu_b)};
			ALU_SLTU: alu_r = {63'b0, alu_a < alu_b};
			ALU_XOR:  alu_r = alu_a ^ alu_b;
			ALU_SRL:  alu_r = d_s1.word ? ({32'b0, alu_a[31:0]} >> sh) : (alu_a >> sh);
			ALU_SRA:  alu_r = d_s1.word ? 64'($signed(sx32(alu_a)) >>> sh)
			                            : 64'($signed(alu_a) >>> sh);
			ALU_OR:   alu_r = alu_a | alu_b;
			ALU_AND:  alu_r = alu_a & alu_b;
			default:  alu_r = alu_a + alu_b;
		endcase
		if (d_s1.word) alu_r = sx32(alu_r);
	end

	assign addr   = rs1_s1 + d_s1.imm;
	assign pc4    = pc_q + 64'd4;
	assign pc_imm = pc_q + d_s1.imm;

	always_comb begin
		case (d_s1.br)
			BR_EQ:   taken = (rs1_s1 == rs2_s1);
			BR_NE:   taken = (rs1_s1 != rs2_s1);
			BR_LT:   taken = $signed(rs1_s1) < $signed(rs2_s1);
			BR_GE:   taken = $signed(rs1_s1) >= $signed(rs2_s1);
			BR_LTU:  taken = rs1_s1 < rs2_s1;
			default: taken = rs1_s1 >= rs2_s1;
		endcase
		case (d_s1.csr)
			CSR_SEL_MEPC:    csr_val = mepc_q;
			CSR_SEL_MCAUSE:  csr_val = mcause_q;
			CSR_SEL_MSTATUS: csr_val = mstatus_q;
			default:         csr_val = mtvec_q;
		endcase
		case (d_s1.mem_lg)
			LG_BYTE: st_data = {56'b0, rs2_s1[7:0]};
			LG_HALF: st_data = {48'b0, rs2_s1[15:0]};
			LG_WORD: st_data = {32'b0, rs2_s1[31:0]};
			default: st_data = rs2_s1;
		endcase
		case (pend_lg_q)
			LG_BYTE: ld_val = {{56{d_s1.load_data[7] & !pend_uns_q}}, d_s1.load_data[7:0]};
			LG_HALF: ld_val = {{48{d_s1.load_data[15] & !pend_uns_q}}, d_s1.load_data[15:0]};
			LG_WORD: ld_val = {{32{d_s1.load_data[31] & !pend_uns_q}}, d_s1.load_data[31:0]};
			default: ld_val = d_s1.load_data;
		endcase
	end

	// Result and side effects of the item in the back end.
	always_comb begin
		res         = '0;
		res.next_pc = pc_q;
		res.status  = STAT_OK;
		wb_req      = 1'b0;
		wb_idx      = d_s1.rd;
		wb_val      = alu_r;
		set_pend    = 1'b0;
		clr_pend    = 1'b0;
		csr_we      = 1'b0;
		ecall       = 1'b0;
		if (d_s1.kind == K_LDATA) begin
			// Load data with nothing pending is dropped.
			if (pend_q) begin
				clr_pend = 1'b1;
				wb_req   = 1'b1;
				wb_idx   = pend_rd_q;
				wb_val   = ld_val;
			end
		end else if (pend_q) begin
			res.status = STAT_LOAD_PND;
		end else begin
			case (d_s1.kind)
				K_ALU: begin
					wb_req      = 1'b1;
					res.next_pc = pc4;
				end
				K_MDU: begin
					wb_req      = 1'b1;
					wb_val      = md_val_q;
					res.next_pc = pc4;
				end
				K_JAL: begin
					wb_req      = 1'b1;
					wb_val      = pc4;
					res.next_pc = pc_imm;
				end
				K_JALR: begin
					wb_req      = 1'b1;
					wb_val      = pc4;
					res.next_pc = {addr[63:1], 1'b0};
				end
				K_BRANCH: res.next_pc = taken ? pc_imm : pc4;
				K_LOAD: begin
					res.mem_kind      = MEM_READ;
					res.mem_address   = addr;
					res.mem_size_log2 = d_s1.mem_lg;
					res.status        = STAT_LOAD_PND;
					res.next_pc       = pc4;
					set_pend          = 1'b1;
				end
				K_STORE: begin
					res.mem_kind       = MEM_WRITE;
					res.mem_address    = addr;
					res.mem_size_log2  = d_s1.mem_lg;
					res.mem_write_data = st_data;
					res.next_pc        = pc4;
				end
				K_CSR: begin
					wb_req      = 1'b1;
					wb_val      = csr_val;
					csr_we      = 1'b1;
					res.next_pc = pc4;
				end
				K_CSR_BAD: res.status = STAT_BAD_CSR;
				K_MRET:    res.next_pc = mepc_q;
				K_ECALL: begin
					ecall       = 1'b1;
					res.next_pc = mtvec_q;
				end
				K_EBREAK: begin
					res.status    = STAT_HALT;
					res.halt_code = rs1_s1;
					res.next_pc   = pc4;
				end
				default: res.status = STAT_ILLEGAL;
			endcase
		end
		if (wb_req && wb_idx != 5'd0) begin
			res.writeback_valid = 1'b1;
			res.writeback_index = wb_idx;
			res.writeback_value = wb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rf_vld_q    <= '0;
			pc_q        <= RESET_PC;
			mepc_q      <= '0;
			mstatus_q   <= '0;
			mcause_q    <= '0;
			mtvec_q     <= '0;
			pend_q      <= 1'b0;
			pend_rd_q   <= '0;
			pend_lg_q   <= '0;
			pend_uns_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_pop) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (mdu_go) state_q <= ST_MDU;
					else if (commit) state_q <= ST_IDLE;
				end
				ST_MDU:  if (md_done) state_q <= ST_FIN;
				ST_FIN:  if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_write) pc_q <= cfg_data;
			else if (commit) pc_q <= res.next_pc;
			if (commit) begin
				if (res.writeback_valid) rf_vld_q[wb_idx] <= 1'b1;
				if (clr_pend) pend_q <= 1'b0;
				if (set_pend) begin
					pend_q     <= 1'b1;
					pend_rd_q  <= d_s1.rd;
					pend_lg_q  <= d_s1.mem_lg;
					pend_uns_q <= d_s1.ld_uns;
				end
				if (ecall) begin
					mepc_q   <= pc_q;
					mcause_q <= CAUSE_ECALL_M;
				end
				if (csr_we) begin
					case (d_s1.csr)
						CSR_SEL_MEPC:    mepc_q <= d_s1.csr_set ? (csr_val | rs1_s1) : rs1_s1;
						CSR_SEL_MCAUSE:  mcause_q <= d_s1.csr_set ? (csr_val | rs1_s1) : rs1_s1;
						CSR_SEL_MSTATUS: mstatus_q <= d_s1.csr_set ? (csr_val | rs1_s1) : rs1_s1;
						default:         mtvec_q <= d_s1.csr_set ? (csr_val | rs1_s1) : rs1_s1;
					endcase
				end
			end
		end
	end

	// Register file: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (commit && res.writeback_valid) rf_mem[wb_idx] <= wb_val;
		if (q_pop) begin
			d_s1   <= q_data;
			rs1_s1 <= rf_vld_q[q_data.rs1] ? rf_mem[q_data.rs1] : '0;
			rs2_s1 <= rf_vld_q[q_data.rs2] ? rf_mem[q_data.rs2] : '0;
		end
		if (md_done) md_val_q <= md_result;
		if (commit) out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

// File: hdl/rv64im_instruction_execute.sv
// RV64IM execute block: front decoder, two-entry queue, back end with the
// register file and an iterative multiply/divide unit.
// Each accepted item is queued, has its registers read, and is executed and
// committed into the output register; a multiply or divide also waits on the
// iterative unit. The back end takes no new item until the last has committed.
// Reset clears all control state and loads the pc with 0x80000000.
`default_nettype none
module rv64im_instruction_execute (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  rvex_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rvex_pkg::out_item_t   out_item,
	input  wire logic             cfg_write,
	input  wire logic [63:0]      cfg_data
);
	import rvex_pkg::*;

	// The front end classifies each item as it is accepted; the decoded
	// micro-op goes straight into the queue, so acceptance depends only on
	// queue space, so the front waits on the back end only through a full queue.
	uop_t push_data, pop_data;
	logic push, push_ready, pop_valid, pop;

	rvex_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_push   (push),
		.q_data   (push_data),
		.q_ready  (push_ready)
	);

	// The queue lets the front keep taking items while the back end is busy
	// with a long multiply or divide or stalled on a full output register.
	rvex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// The back end owns all architectural state. It handles one item at a
	// time: it reads the registers, executes, and commits the state change
	// together with loading the output register. Registers that were never
	// written read as zero through per-entry valid bits, so there is no
	// clearing pass after reset. A configuration write reloads the pc.
	rvex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_pop     (pop),
		.q_data    (pop_data),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

// File: hdl/rvex_checker.sv
// Port-level checks of the RV64IM execute block, bound to the top level.
// Depends on rvex_pkg and rv64im_instruction_execute.
`default_nettype none
module rvex_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  wire logic           out_valid,
	input  wire logic           out_ready,
	input  rvex_pkg::out_item_t out_item
);
	import rvex_pkg::*;

	localparam logic [2:0] MAX_IN_FLIGHT = 3'd4;

	logic [2:0] inflight_q;
	logic       in_fire, out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> inflight_q < MAX_IN_FLIGHT)
		else $error("more items held than the buffering allows");

	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_ILLEGAL |->
			!out_item.writeback_valid && out_item.mem_kind == MEM_NONE)
		else $error("illegal instruction had a side effect");

endmodule

bind rv64im_instruction_execute rvex_checker u_rvex_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire
